### src/weight_triggered_sweep_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weight-triggered sweep sequencer
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHT_TRIGGERED_SWEEP_SEQUENCER_ASSERT_SVH
`define WEIGHT_TRIGGERED_SWEEP_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WTSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WTSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/wtss_pkg.sv
// ----------------------------------------------------------------------------
// wtss_pkg
// Types and constants shared by the sweep sequencer modules.
// ----------------------------------------------------------------------------
package wtss_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESENCE_MARGIN = 3'd0,
        CFG_EMPTY_MARGIN    = 3'd1,
        CFG_SETTLE_MS       = 3'd2,
        CFG_CONVEYOR_MS     = 3'd3,
        CFG_SWEEP_STEPS     = 3'd4
    } t_cfg_index;

    // Register reset values
    localparam logic [11:0] PRESENCE_MARGIN_RST = 12'd300;
    localparam logic [11:0] EMPTY_MARGIN_RST    = 12'd50;
    localparam logic [15:0] SETTLE_MS_RST       = 16'd1000;
    localparam logic [19:0] CONVEYOR_MS_RST     = 20'd10000;
    localparam logic [15:0] SWEEP_STEPS_RST     = 16'd100;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESENT = 2'd1,
        MODE_SWEEP   = 2'd2,
        MODE_CONV    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [11:0] presence_margin;
        logic [11:0] empty_margin;
        logic [15:0] settle_ms;
        logic [19:0] conveyor_ms;
        logic [15:0] sweep_steps;
    } t_cfg;

    // Poll fields other than the force reading
    typedef struct packed {
        logic [31:0] now_ms;
        logic        at_start;
        logic        at_end;
        logic        stepper_busy;
        logic        beam_clear;
    } t_poll;

    // Sequencer state carried from one poll to the next
    typedef struct packed {
        t_mode       mode;
        logic        entry_pending;
        logic        zero_valid;
        logic        idle_last_seen;
        logic [31:0] idle_change_time;
        logic        present_last_seen;
        logic [31:0] present_change_time;
        logic        sweeping_out;
        logic [31:0] conveyor_start_time;
        logic        dir_reg;
    } t_state;

    localparam t_state STATE_RST = '{
        mode:                MODE_IDLE,
        entry_pending:       1'b1,
        zero_valid:          1'b0,
        idle_last_seen:      1'b0,
        idle_change_time:    32'd0,
        present_last_seen:   1'b0,
        present_change_time: 32'd0,
        sweeping_out:        1'b0,
        conveyor_start_time: 32'd0,
        dir_reg:             1'b0
    };

    typedef struct packed {
        t_mode       mode;
        logic        stepper_dir;
        logic [15:0] steps_requested;
        logic        conveyor_on;
    } t_result;

endpackage

### src/weight_triggered_sweep_sequencer.sv
// ----------------------------------------------------------------------------
// weight_triggered_sweep_sequencer
// Nest-weight sequencer: presence detection, sweep and conveyor timing.
// ----------------------------------------------------------------------------
// One poll request is taken every clock cycle while the input side is not
// stalled; the request is held in the input register, then the step logic
// computes next state and result into the output register in a single pass.
// Throughput is one poll per cycle, set by that single-pass step stage;
// the input side stalls only while the output register holds an
// untaken result and the input register is full. Configuration writes are
// taken in any cycle and should only be issued while no poll is in flight.
module weight_triggered_sweep_sequencer
    import wtss_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Poll input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_fsr_raw,
    input  logic [31:0]            i_now_ms,
    input  logic                   i_at_start,
    input  logic                   i_at_end,
    input  logic                   i_stepper_busy,
    input  logic                   i_beam_clear,
    // Result output channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_mode,
    output logic                   o_stepper_dir,
    output logic [15:0]            o_steps_requested,
    output logic                   o_conveyor_on
);

`include "weight_triggered_sweep_sequencer_assert.svh"

    t_cfg                   cfg;
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_fsr;
    t_poll                  r_in_poll;
    logic                   r_out_valid;
    t_result                r_res;
    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_zero_level;
    t_state                 n_state;
    logic [SAMPLE_BITS-1:0] n_zero_level;
    t_result                n_res;
    logic                   adv;

    wtss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    wtss_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .i_fsr_raw    (r_in_fsr),
        .i_poll       (r_in_poll),
        .i_zero_level (r_zero_level),
        .i_state      (r_state),
        .i_cfg        (cfg),
        .o_zero_level (n_zero_level),
        .o_state      (n_state),
        .o_result     (n_res)
    );

    // Move a request on when the output register is free or being emptied
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_fsr                <= i_fsr_raw;
            r_in_poll.now_ms        <= i_now_ms;
            r_in_poll.at_start      <= i_at_start;
            r_in_poll.at_end        <= i_at_end;
            r_in_poll.stepper_busy  <= i_stepper_busy;
            r_in_poll.beam_clear    <= i_beam_clear;
        end
    end

    // Commit state and result together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= STATE_RST;
            r_zero_level <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_state      <= n_state;
                r_zero_level <= n_zero_level;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mode            = r_res.mode;
    assign o_stepper_dir     = r_res.stepper_dir;
    assign o_steps_requested = r_res.steps_requested;
    assign o_conveyor_on     = r_res.conveyor_on;

    `WTSS_ASSERT_NEXT(a_mode_tracks_result, adv, r_state.mode == r_res.mode, "state and result mode differ")
    `WTSS_ASSERT_SAME(a_conv_only_in_conv, r_out_valid && r_res.conveyor_on, r_res.mode == MODE_CONV, "conveyor on outside conveyor mode")
    `WTSS_ASSERT_NEXT(a_zero_sticks, r_state.zero_valid, r_state.zero_valid, "zero weight lost")
    `WTSS_ASSERT_NEXT(a_idle_exit, adv && r_state.mode == MODE_IDLE, r_state.mode == MODE_IDLE || r_state.mode == MODE_PRESENT, "illegal exit from idle")
    `WTSS_ASSERT_NEXT(a_in_hold, r_in_valid && !adv, r_in_valid, "pending request dropped")

endmodule

### src/wtss_cfg_regs.sv
// ----------------------------------------------------------------------------
// wtss_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module wtss_cfg_regs
    import wtss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_cfg_ready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the index; drop writes beyond the register list
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PRESENCE_MARGIN: n_cfg.presence_margin = i_cfg_data[11:0];
                CFG_EMPTY_MARGIN:    n_cfg.empty_margin    = i_cfg_data[11:0];
                CFG_SETTLE_MS:       n_cfg.settle_ms       = i_cfg_data[15:0];
                CFG_CONVEYOR_MS:     n_cfg.conveyor_ms     = i_cfg_data[19:0];
                CFG_SWEEP_STEPS:     n_cfg.sweep_steps     = i_cfg_data[15:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.presence_margin <= PRESENCE_MARGIN_RST;
            r_cfg.empty_margin    <= EMPTY_MARGIN_RST;
            r_cfg.settle_ms       <= SETTLE_MS_RST;
            r_cfg.conveyor_ms     <= CONVEYOR_MS_RST;
            r_cfg.sweep_steps     <= SWEEP_STEPS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### src/wtss_step.sv
// ----------------------------------------------------------------------------
// wtss_step
// Next-state and result logic for one poll of the sweep sequencer.
// ----------------------------------------------------------------------------
module wtss_step
    import wtss_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic [SAMPLE_BITS-1:0] i_fsr_raw,
    input  t_poll                  i_poll,
    input  logic [SAMPLE_BITS-1:0] i_zero_level,
    input  t_state                 i_state,
    input  t_cfg                   i_cfg,
    output logic [SAMPLE_BITS-1:0] o_zero_level,
    output t_state                 o_state,
    output t_result                o_result
);

    // Margin sums are one bit wider than the wider operand, so they never wrap
    localparam int SUM_W = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;

    logic [SAMPLE_BITS-1:0] zero;
    logic [SUM_W-1:0]       fsr_ext;
    logic [SUM_W-1:0]       presence_lim;
    logic [SUM_W-1:0]       empty_lim;
    logic                   seen;
    logic [31:0]            idle_elapsed;
    logic [31:0]            present_elapsed;
    logic [31:0]            conv_start;
    logic [31:0]            conv_elapsed;
    logic                   out_dir;
    logic [15:0]            steps;
    logic                   conv;

    // Latch the first reading as the zero weight
    assign zero         = i_state.zero_valid ? i_zero_level : i_fsr_raw;
    assign o_zero_level = zero;

    assign fsr_ext      = SUM_W'(i_fsr_raw);
    assign presence_lim = SUM_W'(zero) + SUM_W'(i_cfg.presence_margin);
    assign empty_lim    = SUM_W'(zero) + SUM_W'(i_cfg.empty_margin);
    assign seen         = fsr_ext > presence_lim;

    assign idle_elapsed    = i_poll.now_ms - i_state.idle_change_time;
    assign present_elapsed = i_poll.now_ms - i_state.present_change_time;
    assign conv_start      = i_state.entry_pending ? i_poll.now_ms
                                                   : i_state.conveyor_start_time;
    assign conv_elapsed    = i_poll.now_ms - conv_start;
    assign out_dir         = i_state.entry_pending | i_state.sweeping_out;

    // Advance the mode sequence by one poll
    always_comb begin
        o_state            = i_state;
        o_state.zero_valid = 1'b1;
        steps              = 16'd0;
        conv               = 1'b0;
        case (i_state.mode)
            MODE_IDLE: begin
                if (i_state.entry_pending) begin
                    o_state.entry_pending    = 1'b0;
                    o_state.idle_change_time = i_poll.now_ms;
                    o_state.idle_last_seen   = 1'b0;
                end else if (i_state.idle_last_seen != seen) begin
                    o_state.idle_change_time = i_poll.now_ms;
                    o_state.idle_last_seen   = seen;
                end else if (idle_elapsed >= 32'(i_cfg.settle_ms) && seen) begin
                    o_state.mode          = MODE_PRESENT;
                    o_state.entry_pending = 1'b1;
                end
            end
            MODE_PRESENT: begin
                if (i_state.entry_pending) begin
                    o_state.entry_pending       = 1'b0;
                    o_state.present_change_time = i_poll.now_ms;
                    o_state.present_last_seen   = 1'b0;
                end else if (present_elapsed >= 32'(i_cfg.settle_ms)
                             && !i_state.present_last_seen) begin
                    o_state.mode          = (fsr_ext < empty_lim) ? MODE_IDLE : MODE_SWEEP;
                    o_state.entry_pending = 1'b1;
                end
            end
            MODE_SWEEP: begin
                o_state.entry_pending = 1'b0;
                o_state.dir_reg       = ~out_dir;
                if (!i_poll.stepper_busy && i_poll.beam_clear) begin
                    steps = i_cfg.sweep_steps;
                end
                if (out_dir) begin
                    o_state.sweeping_out = ~i_poll.at_end;
                end else begin
                    o_state.sweeping_out = 1'b0;
                    if (i_poll.at_start) begin
                        o_state.mode          = MODE_CONV;
                        o_state.entry_pending = 1'b1;
                    end
                end
            end
            MODE_CONV: begin
                o_state.conveyor_start_time = conv_start;
                if (conv_elapsed < 32'(i_cfg.conveyor_ms)) begin
                    o_state.entry_pending = 1'b0;
                    conv                  = 1'b1;
                end else begin
                    o_state.entry_pending = 1'b1;
                    o_state.mode          = MODE_IDLE;
                end
            end
            default: o_state = i_state;
        endcase
    end

    // Form the result from the updated state
    assign o_result.mode            = o_state.mode;
    assign o_result.stepper_dir     = o_state.dir_reg;
    assign o_result.steps_requested = steps;
    assign o_result.conveyor_on     = conv;

endmodule
